// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== hw/rtl/ght_pkg.sv =====
// package: sizes, action and status codes and command type of the handle table
`default_nettype none
package ght_pkg;
	localparam int SLOTS   = 16;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ACT_W   = 3;
	localparam int IDX_W   = 8;
	localparam int GEN_W   = 32;
	localparam int ST_W    = 3;
	localparam int IN_W    = ACT_W + IDX_W + GEN_W;
	localparam int OUT_W   = ST_W + IDX_W + GEN_W;
	localparam int TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int MDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_SHUTDOWN = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INIT     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ALLOC    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FREE     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CHECK    = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_READY = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_INVALID   = 3'd3;
	localparam logic [ST_W-1:0] ST_STALE     = 3'd4;
	localparam logic [ST_W-1:0] ST_DEFAULT   = 3'd5;

	typedef struct packed {
		logic capture;
		logic exec;
	} ght_cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/generational_handle_table_unit.sv =====
// top level of the generational handle table
//
// usage:
// - s_* channel takes one request item: action, slot index and generation
//   (action 0 shutdown, 1 init, 2 allocate, 3 free, 4 check)
// - m_* channel gives exactly one result item per request: status and,
//   for a successful init or allocate, the new handle
// - an item is taken in a capture cycle and executed in an execute cycle,
//   which waits while an earlier result is still held; a result is visible on
//   m_tvalid in the cycle after the execute cycle; the capture / execute
//   sequence in the controller takes no item until the last has executed
// - the capture cycle also reads the top of the free-slot stack, whose
//   read port is registered; the execute cycle does the table update
// - the result sits in an output register: a new request is taken while
//   a result waits, but its execution holds until the result is taken
// - reset clears the occupied bits, counters and the default handle at
//   once; the block takes items as soon as reset is released, and
//   only allocate after init gives handles
`default_nettype none
`include "assert_macros.svh"
module generational_handle_table_unit
	import ght_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// action [2:0], slot_index [10:3], slot_generation [42:11], zero fill
	input  wire logic [TDATA_W-1:0] s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// status [2:0], handle_index [10:3], handle_generation [42:11], zero fill
	output logic      [MDATA_W-1:0] m_tdata
);
	ght_cmd_t         cmd;
	logic [ST_W-1:0]  res_status;
	logic [IDX_W-1:0] res_index;
	logic [GEN_W-1:0] res_generation;

	// sequencing and output valid
	ght_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// table state and result payload
	ght_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (s_tdata[ACT_W-1:0]),
		.slot_index      (s_tdata[ACT_W+IDX_W-1:ACT_W]),
		.slot_generation (s_tdata[IN_W-1:ACT_W+IDX_W]),
		.res_status      (res_status),
		.res_index       (res_index),
		.res_generation  (res_generation)
	);

	assign m_tdata = {{(MDATA_W - OUT_W){1'b0}}, res_generation, res_index, res_status};

	// one item at a time: after a capture the input side is closed
	`ASSERT_CLK(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")
	// an execute always presents a result next cycle
	`ASSERT_CLK(a_exec_gives_result, cmd.exec |=> m_tvalid, "result lost after execute")
	`ASSERT_NEVER(a_capture_and_exec, cmd.capture && cmd.exec, "capture during execute")
	// results with a status other than ok carry a zero handle
	`ASSERT_CLK(a_zero_handle, (m_tvalid && res_status != ST_OK) |-> (res_index == '0 && res_generation == '0), "handle on failed result")
	`ASSERT_CLK(a_status_range, m_tvalid |-> res_status <= ST_DEFAULT, "status code out of range")
endmodule
`default_nettype wire

// ===== hw/rtl/ght_stack.sv =====
// free-slot stack storage: one write port, one registered read port
`default_nettype none
module ght_stack
	import ght_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_addr,
	input  wire logic [IDX_W-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output logic      [IDX_W-1:0]  rd_data
);
	logic [IDX_W-1:0] mem_q [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ght_ctrl.sv =====
// controller: capture / execute sequencing and output valid
`default_nettype none
module ght_ctrl
	import ght_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output ght_cmd_t  cmd
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ght_dp.sv =====
// datapath: slot table, counters, default handle and result register
`default_nettype none
module ght_dp
	import ght_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ght_cmd_t         cmd,
	input  wire logic [ACT_W-1:0] action,
	input  wire logic [IDX_W-1:0] slot_index,
	input  wire logic [GEN_W-1:0] slot_generation,
	output logic      [ST_W-1:0]  res_status,
	output logic      [IDX_W-1:0] res_index,
	output logic      [GEN_W-1:0] res_generation
);
	logic [ACT_W-1:0]  act_q;
	logic [IDX_W-1:0]  idx_q;
	logic [GEN_W-1:0]  gen_q;
	logic [CNT_W-1:0]  fc_q, fc_d, fc_dec;
	logic [CNT_W-1:0]  hw_q, hw_d;
	logic              ready_q, ready_d;
	logic [IDX_W-1:0]  def_idx_q, def_idx_d;
	logic [GEN_W-1:0]  def_gen_q, def_gen_d;
	logic [SLOTS-1:0]  busy_q;
	logic [GEN_W-1:0]  gen_mem_q [SLOTS];

	logic [IDX_W-1:0]  top_rd;
	logic [SLOT_W-1:0] chk_addr, pop_addr, rd_addr;
	logic [GEN_W-1:0]  gen_rd, gen_bump;
	logic              idx_in_range, pop_ok, fc_nz, fc_lt, hw_full;
	logic [ST_W-1:0]   v_status;

	logic [ST_W-1:0]   st;
	logic [IDX_W-1:0]  oi;
	logic [GEN_W-1:0]  og;
	logic              clr, push;
	logic              gen_we, busy_we, busy_wd;
	logic [SLOT_W-1:0] gen_wa, busy_wa;
	logic [GEN_W-1:0]  gen_wd;

	assign fc_dec = fc_q - CNT_W'(1);

	ght_stack u_stack (
		.clk     (clk),
		.wr_en   (cmd.exec && push),
		.wr_addr (fc_q[SLOT_W-1:0]),
		.wr_data (idx_q),
		.rd_en   (cmd.capture),
		.rd_addr (fc_dec[SLOT_W-1:0]),
		.rd_data (top_rd)
	);

	assign chk_addr     = idx_q[SLOT_W-1:0];
	assign pop_addr     = top_rd[SLOT_W-1:0];
	assign rd_addr      = (act_q == ACT_ALLOC) ? pop_addr : chk_addr;
	assign gen_rd       = gen_mem_q[rd_addr];
	assign gen_bump     = (gen_rd == '1) ? GEN_W'(1) : gen_rd + GEN_W'(1);
	assign idx_in_range = {{CNT_W{1'b0}}, idx_q} < {{IDX_W{1'b0}}, hw_q};
	assign pop_ok       = {1'b0, top_rd} < (IDX_W + 1)'(SLOTS);
	assign fc_nz        = (fc_q != '0);
	assign fc_lt        = fc_q < CNT_W'(SLOTS);
	assign hw_full      = hw_q >= CNT_W'(SLOTS);

	// handle validation for free and check
	always_comb begin
		if (gen_q == '0 || !idx_in_range) begin
			v_status = ST_INVALID;
		end else if (!busy_q[chk_addr] || gen_rd != gen_q) begin
			v_status = ST_STALE;
		end else begin
			v_status = ST_OK;
		end
	end

	always_comb begin
		st        = ST_INVALID;
		oi        = '0;
		og        = '0;
		clr       = 1'b0;
		push      = 1'b0;
		fc_d      = fc_q;
		hw_d      = hw_q;
		ready_d   = ready_q;
		def_idx_d = def_idx_q;
		def_gen_d = def_gen_q;
		gen_we    = 1'b0;
		gen_wa    = chk_addr;
		gen_wd    = gen_bump;
		busy_we   = 1'b0;
		busy_wa   = chk_addr;
		busy_wd   = 1'b0;
		case (act_q)
			ACT_SHUTDOWN: begin
				st        = ST_OK;
				clr       = 1'b1;
				fc_d      = '0;
				hw_d      = '0;
				ready_d   = 1'b0;
				def_idx_d = '0;
				def_gen_d = '0;
			end
			ACT_INIT: begin
				// clear, then slot 0 generation 1 becomes the default
				st        = ST_OK;
				clr       = 1'b1;
				fc_d      = '0;
				hw_d      = CNT_W'(1);
				ready_d   = 1'b1;
				def_idx_d = '0;
				def_gen_d = GEN_W'(1);
				gen_we    = 1'b1;
				gen_wa    = '0;
				gen_wd    = GEN_W'(1);
				busy_we   = 1'b1;
				busy_wa   = '0;
				busy_wd   = 1'b1;
				og        = GEN_W'(1);
			end
			ACT_ALLOC: begin
				if (!ready_q) begin
					st = ST_NOT_READY;
				end else if (fc_nz) begin
					fc_d = fc_dec;
					if (!pop_ok) begin
						st = ST_FULL;
					end else begin
						st      = ST_OK;
						busy_we = 1'b1;
						busy_wa = pop_addr;
						busy_wd = 1'b1;
						oi      = top_rd;
						og      = gen_rd;
					end
				end else if (hw_full) begin
					st = ST_FULL;
				end else begin
					st      = ST_OK;
					hw_d    = hw_q + CNT_W'(1);
					gen_we  = 1'b1;
					gen_wa  = hw_q[SLOT_W-1:0];
					gen_wd  = GEN_W'(1);
					busy_we = 1'b1;
					busy_wa = hw_q[SLOT_W-1:0];
					busy_wd = 1'b1;
					oi      = IDX_W'(hw_q);
					og      = GEN_W'(1);
				end
			end
			ACT_FREE: begin
				if (idx_q == def_idx_q && gen_q == def_gen_q) begin
					st = ST_DEFAULT;
				end else begin
					st = v_status;
					if (v_status == ST_OK) begin
						busy_we = 1'b1;
						gen_we  = 1'b1;
						if (fc_lt) begin
							push = 1'b1;
							fc_d = fc_q + CNT_W'(1);
						end
					end
				end
			end
			ACT_CHECK: begin
				st = v_status;
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			idx_q <= slot_index;
			gen_q <= slot_generation;
		end
	end

	// generations: slots at or above the high-water count are never used
	always_ff @(posedge clk) begin
		if (cmd.exec && gen_we) begin
			gen_mem_q[gen_wa] <= gen_wd;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status     <= st;
			res_index      <= oi;
			res_generation <= og;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= '0;
			hw_q      <= '0;
			ready_q   <= 1'b0;
			def_idx_q <= '0;
			def_gen_q <= '0;
			busy_q    <= '0;
		end else if (cmd.exec) begin
			fc_q      <= fc_d;
			hw_q      <= hw_d;
			ready_q   <= ready_d;
			def_idx_q <= def_idx_d;
			def_gen_q <= def_gen_d;
			if (clr) begin
				busy_q <= '0;
			end
			if (busy_we) begin
				busy_q[busy_wa] <= busy_wd;
			end
		end
	end
endmodule
`default_nettype wire

// ===== dv/generational_handle_table_unit_tb.sv =====
// testbench for the generational handle table: streamed requests checked against a predictor
`timescale 1ns / 100ps
module generational_handle_table_unit_tb;
	import ght_pkg::*;

	// actions with no meaning in the block; they answer invalid
	localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd5;
	localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd6;
	localparam logic [ACT_W-1:0] ACT_RSVD_C = 3'd7;

	localparam int N_DIRECTED   = 23;
	localparam int N_RANDOM     = 750;
	localparam int N_TOTAL      = N_DIRECTED + N_RANDOM;
	localparam int MODE_SPAN    = 40;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int REPORT_MAX   = 100;

	// request item, action in the low bits as on s_tdata
	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [IDX_W-1:0] idx;
		logic [ACT_W-1:0] action;
	} request_t;

	// result item, status in the low bits as on m_tdata
	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [IDX_W-1:0] idx;
		logic [ST_W-1:0]  status;
	} reply_t;

	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [IDX_W-1:0] idx;
	} handle_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [MDATA_W-1:0] m_tdata;

	generational_handle_table_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// request items waiting for the driver, replies waiting for the block
	request_t request_queue[$];
	reply_t   predicted_replies[$];

	// handles known to be live, and handles that were freed since
	handle_t  live_handles[$];
	handle_t  retired_handles[$];

	logic s_taken      = 1'b0;
	int   sent_cnt     = 0;
	int   replies_seen = 0;
	int   err_cnt      = 0;
	int   cycle_cnt    = 0;
	int   hold_cnt     = 0;
	logic hold_done    = 1'b0;

	// predicted table state
	logic [GEN_W-1:0] tbl_gen [SLOTS];
	logic             tbl_busy [SLOTS];
	logic [IDX_W-1:0] recycled [SLOTS];
	logic [CNT_W-1:0] recycled_cnt;
	logic [CNT_W-1:0] fresh_mark;
	logic             tbl_ready;
	logic [IDX_W-1:0] dflt_idx;
	logic [GEN_W-1:0] dflt_gen;

	function automatic void wipe_table();
		for (int k = 0; k < SLOTS; k++) begin
			tbl_gen[k]  = 1;
			tbl_busy[k] = 1'b0;
			recycled[k] = '0;
		end
		recycled_cnt = '0;
		fresh_mark   = '0;
		tbl_ready    = 1'b0;
		dflt_idx     = '0;
		dflt_gen     = '0;
	endfunction

	// pops a recycled slot first, else appends a fresh one at generation 1
	function automatic reply_t claim_slot();
		reply_t           r;
		logic [IDX_W-1:0] i;
		r = '0;
		i = '0;
		if (!tbl_ready) begin
			r.status = ST_NOT_READY;
		end else begin
			r.status = ST_OK;
			if (recycled_cnt > 0 && recycled_cnt <= SLOTS) begin
				recycled_cnt = recycled_cnt - 1'b1;
				i = recycled[recycled_cnt];
				if (i >= SLOTS)
					r.status = ST_FULL;
			end else if (fresh_mark >= SLOTS) begin
				r.status = ST_FULL;
			end else begin
				i = IDX_W'(fresh_mark);
				fresh_mark = fresh_mark + 1'b1;
				tbl_gen[i] = 1;
			end
			if (r.status == ST_OK) begin
				tbl_busy[i] = 1'b1;
				r.idx = i;
				r.gen = tbl_gen[i];
			end
		end
		return r;
	endfunction

	function automatic logic [ST_W-1:0] vet_handle(logic [IDX_W-1:0] idx,
			logic [GEN_W-1:0] gen);
		if (gen == 0 || idx >= fresh_mark || idx >= SLOTS)
			return ST_INVALID;
		if (!tbl_busy[idx] || tbl_gen[idx] != gen)
			return ST_STALE;
		return ST_OK;
	endfunction

	// works out the reply to one request and updates the predicted table
	function automatic reply_t resolve_request(request_t rq);
		reply_t           r;
		logic [GEN_W-1:0] g;
		r = '0;
		r.status = ST_INVALID;
		case (rq.action)
			ACT_SHUTDOWN: begin
				wipe_table();
				r.status = ST_OK;
			end
			ACT_INIT: begin
				wipe_table();
				tbl_ready = 1'b1;
				r = claim_slot();
				if (r.status == ST_OK) begin
					dflt_idx = r.idx;
					dflt_gen = r.gen;
				end
			end
			ACT_ALLOC: begin
				r = claim_slot();
			end
			ACT_FREE: begin
				if (rq.idx == dflt_idx && rq.gen == dflt_gen) begin
					r.status = ST_DEFAULT;
				end else begin
					r.status = vet_handle(rq.idx, rq.gen);
					if (r.status == ST_OK) begin
						tbl_busy[rq.idx] = 1'b0;
						// generation skips zero on wrap
						g = tbl_gen[rq.idx] + 1;
						if (g == 0)
							g = 1;
						tbl_gen[rq.idx] = g;
						if (recycled_cnt < SLOTS) begin
							recycled[recycled_cnt] = rq.idx;
							recycled_cnt = recycled_cnt + 1'b1;
						end
					end
				end
			end
			ACT_CHECK: begin
				r.status = vet_handle(rq.idx, rq.gen);
			end
			default: begin
				r.status = ST_INVALID;
			end
		endcase
		// handle fields only travel with a good init or allocate
		if (r.status != ST_OK) begin
			r.idx = '0;
			r.gen = '0;
		end
		return r;
	endfunction

	function automatic int phase_of(int n);
		if (n < N_TOTAL / 3)
			return 0;
		if (n < (2 * N_TOTAL) / 3)
			return 1;
		return 2;
	endfunction

	// random request: allocate, free and check of real handles, some stale and noise
	function automatic request_t pick_request(logic fill_mode);
		request_t rq;
		handle_t  h;
		int       r;
		int       alloc_hi;
		int       free_hi;
		int       check_hi;
		rq.action = ACT_ALLOC;
		rq.idx    = IDX_W'($urandom_range(0, 255));
		rq.gen    = $urandom;
		alloc_hi  = fill_mode ? 50 : 15;
		free_hi   = fill_mode ? 65 : 55;
		check_hi  = fill_mode ? 77 : 70;
		r = $urandom_range(0, 99);
		if (r < alloc_hi) begin
			rq.action = ACT_ALLOC;
		end else if (r < 89 && live_handles.size() == 0) begin
			// nothing live after a shutdown: bring the table back
			rq.action = ACT_INIT;
		end else if (r < check_hi) begin
			h = live_handles[$urandom_range(0, live_handles.size() - 1)];
			rq.action = (r < free_hi) ? ACT_FREE : ACT_CHECK;
			rq.idx = h.idx;
			rq.gen = h.gen;
		end else if (r < 89) begin
			rq.action = $urandom_range(0, 1) ? ACT_FREE : ACT_CHECK;
			if (retired_handles.size() != 0 && $urandom_range(0, 1)) begin
				h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
			end else begin
				h = live_handles[$urandom_range(0, live_handles.size() - 1)];
				case ($urandom_range(0, 3))
					0: h.gen = h.gen + 1;
					1: h.gen = h.gen - 1;
					2: h.gen = '0;
					default: h.idx = IDX_W'($urandom_range(SLOTS, 255));
				endcase
			end
			rq.idx = h.idx;
			rq.gen = h.gen;
		end else if (r < 97) begin
			rq.action = ACT_W'($urandom_range(ACT_FREE, ACT_RSVD_C));
		end else if (r < 99) begin
			rq.action = ACT_INIT;
		end else begin
			rq.action = ACT_SHUTDOWN;
		end
		return rq;
	endfunction

	task automatic queue_req(logic [ACT_W-1:0] action, logic [IDX_W-1:0] idx,
			logic [GEN_W-1:0] gen);
		request_t rq;
		rq.action = action;
		rq.idx    = idx;
		rq.gen    = gen;
		request_queue.insert(request_queue.size(), rq);
	endtask

	// step to a point between edges, clear of driver and monitor
	task automatic tick_mid();
		@(posedge clk);
		#1;
	endtask

	// sender: a new item is offered at the falling edge once the last one is gone
	always @(negedge clk) begin
		int idle_pct;
		case (phase_of(sent_cnt))
			0:       idle_pct = 17;
			1:       idle_pct = 57;
			default: idle_pct = 0;
		endcase
		if (!s_tvalid || s_taken) begin
			if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				s_tdata  <= TDATA_W'(request_queue.pop_front());
				s_tvalid <= 1'b1;
				sent_cnt <= sent_cnt + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(negedge clk) begin
		int idle_pct;
		case (phase_of(sent_cnt))
			0:       idle_pct = 57;
			1:       idle_pct = 17;
			default: idle_pct = 0;
		endcase
		if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && replies_seen >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_cnt  <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// monitor: check replies against the oldest prediction, predict each taken request
	always @(posedge clk) begin
		reply_t   got;
		reply_t   want;
		request_t rq;
		int       k;
		if (arst_n) begin
			s_taken = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_W-1:0];
				replies_seen++;
				if (predicted_replies.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_MAX)
						$display("%0t: reply with none awaited: status %0d idx %0d gen %h",
							$time, got.status, got.idx, got.gen);
				end else begin
					want = predicted_replies.pop_front();
					if (got.status !== want.status || got.idx !== want.idx ||
							got.gen !== want.gen) begin
						err_cnt++;
						if (err_cnt <= REPORT_MAX)
							$display("%0t: reply mismatch:", $time,
								" expected status %0d idx %0d gen %h,",
								want.status, want.idx, want.gen,
								" got status %0d idx %0d gen %h",
								got.status, got.idx, got.gen);
					end
				end
			end
			if (s_taken) begin
				rq   = s_tdata[IN_W-1:0];
				want = resolve_request(rq);
				predicted_replies.insert(predicted_replies.size(), want);
				// keep the pools of known handles in step with the table
				if (rq.action == ACT_SHUTDOWN || rq.action == ACT_INIT)
					live_handles.delete();
				if ((rq.action == ACT_INIT || rq.action == ACT_ALLOC) && want.status == ST_OK)
					live_handles.insert(live_handles.size(), {want.gen, want.idx});
				if (rq.action == ACT_FREE && want.status == ST_OK) begin
					for (k = live_handles.size() - 1; k >= 0; k--)
						if (live_handles[k].idx == rq.idx && live_handles[k].gen == rq.gen)
							live_handles.delete(k);
					if (retired_handles.size() >= SLOTS)
						void'(retired_handles.pop_front());
					retired_handles.insert(retired_handles.size(), {rq.gen, rq.idx});
				end
			end
		end
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic fill_mode;
		wipe_table();
		fill_mode = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// before init: nothing ready, default is all zero
		queue_req(ACT_ALLOC, 8'd0, 32'd0);
		queue_req(ACT_FREE, 8'd0, 32'd0);
		queue_req(ACT_CHECK, 8'd0, 32'd0);
		queue_req(ACT_FREE, 8'd3, 32'd5);
		// unknown actions with every field bit set
		queue_req(ACT_RSVD_A, 8'hff, 32'hffff_ffff);
		queue_req(ACT_RSVD_B, 8'hff, 32'hffff_ffff);
		queue_req(ACT_RSVD_C, 8'hff, 32'hffff_ffff);
		// init makes the default, which cannot be freed
		queue_req(ACT_INIT, 8'd0, 32'd0);
		queue_req(ACT_FREE, 8'd0, 32'd1);
		queue_req(ACT_CHECK, 8'd0, 32'd1);
		queue_req(ACT_CHECK, 8'd0, 32'd0);
		// allocate, wrong generation, free, double free, reuse from the stack
		queue_req(ACT_ALLOC, 8'hff, 32'hffff_ffff);
		queue_req(ACT_CHECK, 8'd1, 32'd2);
		queue_req(ACT_FREE, 8'd1, 32'd1);
		queue_req(ACT_CHECK, 8'd1, 32'd1);
		queue_req(ACT_FREE, 8'd1, 32'd1);
		queue_req(ACT_ALLOC, 8'd0, 32'd0);
		// index at and far past the high-water count
		queue_req(ACT_CHECK, 8'd2, 32'd1);
		queue_req(ACT_CHECK, 8'hff, 32'hffff_ffff);
		queue_req(ACT_FREE, 8'd0, 32'd0);
		// shutdown drops everything, init brings it back
		queue_req(ACT_SHUTDOWN, 8'hff, 32'hffff_ffff);
		queue_req(ACT_CHECK, 8'd0, 32'd1);
		queue_req(ACT_INIT, 8'hff, 32'hffff_ffff);

		// alternate fill-heavy and drain-heavy stretches so the table hits full
		for (int n = 0; n < N_RANDOM; n++) begin
			while (request_queue.size() != 0)
				tick_mid();
			if (n % MODE_SPAN == 0)
				fill_mode = ~fill_mode;
			request_queue.insert(request_queue.size(), pick_request(fill_mode));
		end

		while (request_queue.size() != 0 || s_tvalid || predicted_replies.size() != 0)
			tick_mid();
		repeat (DRAIN_CYCLES) tick_mid();
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
